[sv/sync_length_checksum_deframer_core_macros.svh]
// assertion macros for the sync/length/checksum deframer
// depends on nothing; included by sync_length_checksum_deframer_core.sv
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SLCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/slcd_pkg.sv]
// types and constants of the sync/length/checksum deframer
// depends on nothing
package slcd_pkg;

   // sync byte that opens a frame and seeds the checksum
   localparam logic [7:0] FRAME_SYNC = 8'h55;

   // store slots ahead of the data: command and length
   localparam int HDR_BYTES = 2;

   // frame receive and replay sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_LEN,
      ST_BODY,
      ST_FETCH,
      ST_LOAD
   } state_type;

endpackage

[sv/sync_length_checksum_deframer_core.sv]
// Sync/length/checksum frame receiver: usage
// req_* carries received serial bytes, one word per accepted handshake.
// While idle every word but the sync byte 0x55 is dropped. After sync the
// block takes a command word, a length word (above MAX_DATA abandons the
// frame), that many data words and a checksum word. The checksum must equal
// 0x55 plus command, length and data words, modulo 256.
// rsp_* replays a good frame as command, length, data words, rsp_tlast on
// the final one. A bad frame gives no words.
// Throughput: one input word per cycle while a frame is being received.
// After the checksum word req_tready stays low for the replay, which reads
// the frame memory one word per cycle: after the checksum is accepted the
// fetch state reads the first word into the read register, and it moves on
// into the output register, then one word per cycle that rsp_tready is
// high. The single memory read port sets that pace.
// A stalled receiver holds the replay; the last word sits in the output
// register while the block already takes the next input word.
// Reset (synchronous, active high) returns to idle and drops any frame in
// progress or in replay; the frame memory is not cleared.
// depends on slcd_pkg and sync_length_checksum_deframer_core_macros.svh
`include "sync_length_checksum_deframer_core_macros.svh"

module sync_length_checksum_deframer_core #(
   parameter int MAX_DATA = 15
) (
   input  logic       clock,
   input  logic       reset,
   // received byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   // checked frame stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic       rsp_tlast    // last_byte
);
   import slcd_pkg::*;

   localparam int STORE_DEPTH = MAX_DATA + 3;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(MAX_DATA + 1);

   // frame memory: command, length, data words
   logic [7:0]       mem [STORE_DEPTH];

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]       rd_q_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_last_ff;

   logic             req_acc;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             out_free;
   logic             out_load;
   logic             at_checksum;
   logic             at_last;

   assign req_acc     = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign at_checksum = idx_ff == (IDX_W'(len_ff) + IDX_W'(HDR_BYTES));
   assign at_last     = rd_ptr_ff == (IDX_W'(len_ff) + IDX_W'(HDR_BYTES - 1));

   // input is taken in every receive state, held off during replay
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_CMD) ||
                       (state_ff == ST_LEN)  || (state_ff == ST_BODY);

   // sequencer: receive, check, replay
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      rd_ptr_in = rd_ptr_ff;
      mem_we    = 1'b0;
      wr_addr   = idx_ff;
      rd_en     = 1'b0;
      rd_addr   = rd_ptr_ff;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tdata == FRAME_SYNC)) begin
               sum_in   = FRAME_SYNC;
               state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (req_acc) begin
               mem_we   = 1'b1;
               wr_addr  = '0;
               sum_in   = sum_ff + req_tdata;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (req_acc) begin
               if (req_tdata > 8'(MAX_DATA)) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_we   = 1'b1;
                  wr_addr  = IDX_W'(1);
                  len_in   = req_tdata[LEN_W-1:0];
                  sum_in   = sum_ff + req_tdata;
                  idx_in   = IDX_W'(HDR_BYTES);
                  state_in = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (req_acc) begin
               if (at_checksum) begin
                  rd_ptr_in = '0;
                  state_in  = (req_tdata == sum_ff) ? ST_FETCH : ST_IDLE;
               end else begin
                  mem_we = 1'b1;
                  sum_in = sum_ff + req_tdata;
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FETCH: begin
            // no writes during replay, so reads never race a write
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_load = 1'b1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_ptr_ff + IDX_W'(1);
                  rd_ptr_in = rd_ptr_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= FRAME_SYNC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // counters and output word
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      len_ff    <= len_in;
      rd_ptr_ff <= rd_ptr_in;
      if (out_load) begin
         rsp_data_ff <= rd_q_ff;
         rsp_last_ff <= at_last;
      end
   end

   // frame memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // replay always starts at the command word
   `SLCD_ASSERT_NOW(a_fetch_from_start, state_ff == ST_FETCH, rd_ptr_ff == '0,
                    "replay not at start")
   // body index never runs past the checksum slot
   `SLCD_ASSERT_NOW(a_body_bound, state_ff == ST_BODY,
                    idx_ff <= (IDX_W'(len_ff) + IDX_W'(HDR_BYTES)), "body index past checksum")
   // loading the final word ends the replay and shows tlast
   `SLCD_ASSERT_NEXT(a_last_ends, out_load && at_last,
                     (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast,
                     "replay did not end on last word")

endmodule
